// ----- design/rdps_pkg.sv -----
// Package for the real DFT polar spectrum block.
// Holds the shared widths, the CORDIC arctangent table and the twiddle function.
// No dependencies.
package rdps_pkg;

   localparam int SAMPLE_W = 16;
   localparam int BIN_W = 6;
   localparam int MAG_W = 16;
   localparam int PHASE_W = 16;
   localparam int TWID_W = 17;
   localparam int ACC_W = 40;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W = 4;
   localparam int ANGLE_W = 18;
   localparam int INV_GAIN = 652032874;
   localparam int INV_GAIN_W = 30;
   localparam int DEF_POINTS = 64;
   localparam logic [MAG_W-1:0] DEF_FLOOR = 16'd16;
   localparam logic [PHASE_W-1:0] ZERO_VECTOR_PHASE = 16'd49152;
   localparam logic [ANGLE_W-1:0] HALF_TURN = 18'd32768;

   // Arctangent of 2^-i in turn units (65536 = one turn)
   localparam int ATAN_TURN [CORDIC_STEPS] = '{
      8192, 4836, 2555, 1297, 651, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   // Rotation CORDIC for one twiddle; evaluated at elaboration only.
   // Returns {cos, sin}, each signed Q1.15 in 17 bits.
   function automatic logic [2*TWID_W-1:0] twiddle(input longint theta);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint q;
      longint cs;
      longint sn;
      logic [TWID_W-1:0] cs_b;
      logic [TWID_W-1:0] sn_b;
      x = INV_GAIN;
      y = 0;
      z = theta & 16383;
      q = (theta >> 14) & 3;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURN[i];
         end
      end
      x = (x + 16384) >>> 15;
      y = (y + 16384) >>> 15;
      case (q)
         0: begin
            cs = x;
            sn = y;
         end
         1: begin
            cs = -y;
            sn = x;
         end
         2: begin
            cs = -x;
            sn = -y;
         end
         default: begin
            cs = y;
            sn = -x;
         end
      endcase
      cs_b = cs[TWID_W-1:0];
      sn_b = sn[TWID_W-1:0];
      return {cs_b, sn_b};
   endfunction

endpackage

// ----- design/rdps_cell.sv -----
// One sample cell of the frame chain.
// Holds one sample and takes its neighbor's value on every shift.
// Depends on rdps_pkg.
module rdps_cell (
   input  logic                           clock,
   input  logic                           shift,
   input  logic [rdps_pkg::SAMPLE_W-1:0]  data_in,
   output logic [rdps_pkg::SAMPLE_W-1:0]  data_out
);
   import rdps_pkg::*;

   logic [SAMPLE_W-1:0] data_ff;

   // advance the chain
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// ----- design/rdps_polar.sv -----
// Iterative CORDIC vectoring unit: rectangular bin to magnitude and phase.
// One micro-rotation per cycle, then a registered gain multiply.
// Depends on rdps_pkg.
module rdps_polar (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [rdps_pkg::ACC_W-1:0]  re,
   input  logic signed [rdps_pkg::ACC_W-1:0]  im,
   output logic                               done,
   output logic [rdps_pkg::MAG_W-1:0]         magnitude,
   output logic [rdps_pkg::PHASE_W-1:0]       phase
);
   import rdps_pkg::*;

   localparam int VEC_W = ACC_W + 2;
   localparam int XM_W = 33;
   localparam int PROD_W = XM_W + INV_GAIN_W;

   typedef enum logic [1:0] {P_IDLE, P_ITER, P_MUL, P_FIN} pstate_type;

   pstate_type               state_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [VEC_W-1:0]  x_ff;
   logic signed [VEC_W-1:0]  y_ff;
   logic signed [ANGLE_W-1:0] z_ff;
   logic                     zero_ff;
   logic                     sat_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     done_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [PHASE_W-1:0]       phase_ff;

   logic signed [VEC_W-1:0]  dx;
   logic signed [VEC_W-1:0]  dy;
   logic signed [ANGLE_W-1:0] atan;
   logic [XM_W-1:0]          m1;
   logic [XM_W:0]            m_sum;
   logic [XM_W-16:0]         m2;
   logic [PROD_W-1:0]        prod_in;

   // shifted terms of the current micro-rotation
   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      atan = ANGLE_W'(ATAN_TURN[step_ff]);
      prod_in = PROD_W'(x_ff[XM_W-1:0]) * PROD_W'(INV_GAIN);
      m1 = prod_ff[PROD_W-1:INV_GAIN_W];
      m_sum = {1'b0, m1} + (XM_W+1)'(32768);
      m2 = m_sum[XM_W:16];
   end

   // sequence rotations, gain multiply and rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff <= 1'b0;
      end else begin
         case (state_ff)
            P_IDLE: begin
               if (start) begin
                  done_ff <= 1'b0;
                  state_ff <= P_ITER;
                  step_ff <= '0;
                  zero_ff <= (re == '0) && (im == '0);
                  if (re < 0) begin
                     x_ff <= -VEC_W'(re);
                     y_ff <= -VEC_W'(im);
                     z_ff <= HALF_TURN;
                  end else begin
                     x_ff <= VEC_W'(re);
                     y_ff <= VEC_W'(im);
                     z_ff <= '0;
                  end
               end
            end
            P_ITER: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan;
               end else begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= P_MUL;
               end
            end
            P_MUL: begin
               // magnitudes this large saturate anyway
               sat_ff <= |x_ff[VEC_W-1:XM_W];
               prod_ff <= prod_in;
               state_ff <= P_FIN;
            end
            P_FIN: begin
               if (zero_ff) begin
                  mag_ff <= '0;
                  phase_ff <= ZERO_VECTOR_PHASE;
               end else begin
                  if (sat_ff || (|m2[XM_W-16:MAG_W])) begin
                     mag_ff <= '1;
                  end else begin
                     mag_ff <= m2[MAG_W-1:0];
                  end
                  phase_ff <= z_ff[PHASE_W-1:0];
               end
               done_ff <= 1'b1;
               state_ff <= P_IDLE;
            end
            default: begin
               state_ff <= P_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign magnitude = mag_ff;
   assign phase = phase_ff;

endmodule

// ----- design/real_dft_polar_spectrum.sv -----
// Top level of the real DFT polar spectrum block.
// Depends on rdps_pkg, rdps_cell and rdps_polar.
//
// Loads a frame of POINTS signed Q1.15 samples, one per accepted transaction, into
// a chain of sample cells, then emits POINTS/2+1 bins (index, Q2.14 magnitude,
// phase in turn units, last flag). Samples are taken one per cycle until the
// frame is full; then input stalls while the bins are computed. Each bin passes
// through the cosine and sine multiply-accumulates as the chain rotates once past
// them, a drain of the product register, a scale step, the iterative CORDIC
// vectoring unit (16 rotations, gain multiply, rounding and done) and a load of
// the result register. A bin that finds the result register still stalled waits
// until it is taken. Magnitudes below the floor register read as zero.
module real_dft_polar_spectrum #(
   parameter int POINTS = rdps_pkg::DEF_POINTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [rdps_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rdps_pkg::BIN_W-1:0]       rsp_bin_index,
   output logic [rdps_pkg::MAG_W-1:0]       rsp_bin_magnitude,
   output logic [rdps_pkg::PHASE_W-1:0]     rsp_bin_phase,
   output logic                             rsp_last_bin,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rdps_pkg::MAG_W-1:0]       csr_magnitude_floor
);
   import rdps_pkg::*;

   localparam int IDX_W = $clog2(POINTS);
   localparam int PROD_W = 2 * TWID_W;
   localparam logic [BIN_W-1:0] LAST_K = BIN_W'(POINTS / 2);

   typedef enum logic [2:0] {
      ST_LOAD, ST_MAC, ST_DRAIN, ST_SCALE, ST_POLAR, ST_PUT
   } state_type;

   state_type                 state_ff;
   logic [IDX_W-1:0]          pos_ff;
   logic [IDX_W-1:0]          n_ff;
   logic [IDX_W-1:0]          m_ff;
   logic [BIN_W-1:0]          k_ff;
   logic                      pv_ff;
   logic signed [PROD_W-1:0]  prod_c_ff;
   logic signed [PROD_W-1:0]  prod_s_ff;
   logic signed [ACC_W-1:0]   acc_c_ff;
   logic signed [ACC_W-1:0]   acc_s_ff;
   logic [MAG_W-1:0]          floor_ff;
   logic                      rsp_valid_ff;
   logic [BIN_W-1:0]          bin_ff;
   logic [MAG_W-1:0]          mag_ff;
   logic [PHASE_W-1:0]        phase_ff;
   logic                      last_ff;

   logic signed [TWID_W-1:0]  cos_tab [POINTS];
   logic signed [TWID_W-1:0]  sin_tab [POINTS];
   logic [SAMPLE_W-1:0]       cell_q [POINTS];
   logic [SAMPLE_W-1:0]       cell_d [POINTS];

   logic                      req_take;
   logic                      shift;
   logic [IDX_W:0]            m_sum;
   logic [IDX_W-1:0]          m_in;
   logic signed [TWID_W-1:0]  x_ext;
   logic signed [ACC_W-1:0]   re_sc;
   logic signed [ACC_W-1:0]   im_sc;
   logic                      polar_start;
   logic                      polar_done;
   logic [MAG_W-1:0]          polar_mag;
   logic [PHASE_W-1:0]        polar_phase;
   logic                      out_free;

   // twiddle tables, fixed at elaboration
   for (genvar g = 0; g < POINTS; g++) begin : g_twid
      localparam longint THETA = (longint'(g) * 65536 + POINTS / 2) / POINTS;
      localparam logic [PROD_W-1:0] TW = twiddle(THETA);
      assign cos_tab[g] = TW[PROD_W-1:TWID_W];
      assign sin_tab[g] = TW[TWID_W-1:0];
   end

   // sample chain: load at the tail, rotate head to tail while computing
   for (genvar g = 0; g < POINTS; g++) begin : g_chain
      if (g == POINTS - 1) begin : g_tail
         assign cell_d[g] = (state_ff == ST_LOAD) ? req_sample_value : cell_q[0];
      end else begin : g_body
         assign cell_d[g] = cell_q[g+1];
      end
      rdps_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .data_in  (cell_d[g]),
         .data_out (cell_q[g])
      );
   end

   // handshake and datapath terms
   always_comb begin
      req_take = req_valid && !req_stall;
      shift = req_take || (state_ff == ST_MAC);
      m_sum = {1'b0, m_ff} + (IDX_W+1)'(k_ff[IDX_W-1:0]);
      if (m_sum >= (IDX_W+1)'(POINTS)) begin
         m_in = IDX_W'(m_sum - (IDX_W+1)'(POINTS));
      end else begin
         m_in = m_sum[IDX_W-1:0];
      end
      x_ext = TWID_W'($signed(cell_q[0]));
      re_sc = ACC_W'((acc_c_ff * 2) / POINTS);
      im_sc = ACC_W'((acc_s_ff * 2) / POINTS);
      polar_start = (state_ff == ST_SCALE);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   rdps_polar u_polar (
      .clock     (clock),
      .reset     (reset),
      .start     (polar_start),
      .re        (re_sc),
      .im        (im_sc),
      .done      (polar_done),
      .magnitude (polar_mag),
      .phase     (polar_phase)
   );

   // sequencer, accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         pos_ff <= '0;
         pv_ff <= 1'b0;
         floor_ff <= DEF_FLOOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            floor_ff <= csr_magnitude_floor;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // product stage
         pv_ff <= (state_ff == ST_MAC);
         prod_c_ff <= PROD_W'(x_ext * cos_tab[m_ff]);
         prod_s_ff <= PROD_W'(x_ext * sin_tab[m_ff]);
         if (pv_ff) begin
            acc_c_ff <= acc_c_ff + ACC_W'(prod_c_ff);
            acc_s_ff <= acc_s_ff + ACC_W'(prod_s_ff);
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_take) begin
                  if (pos_ff == IDX_W'(POINTS - 1)) begin
                     pos_ff <= '0;
                     k_ff <= '0;
                     n_ff <= '0;
                     m_ff <= '0;
                     acc_c_ff <= '0;
                     acc_s_ff <= '0;
                     state_ff <= ST_MAC;
                  end else begin
                     pos_ff <= pos_ff + 1'b1;
                  end
               end
            end
            ST_MAC: begin
               n_ff <= n_ff + 1'b1;
               m_ff <= m_in;
               if (n_ff == IDX_W'(POINTS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff <= ST_POLAR;
            end
            ST_POLAR: begin
               if (polar_done) begin
                  state_ff <= ST_PUT;
               end
            end
            ST_PUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  bin_ff <= k_ff;
                  mag_ff <= (polar_mag < floor_ff) ? '0 : polar_mag;
                  phase_ff <= polar_phase;
                  last_ff <= (k_ff == LAST_K);
                  if (k_ff == LAST_K) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                     n_ff <= '0;
                     m_ff <= '0;
                     acc_c_ff <= '0;
                     acc_s_ff <= '0;
                     state_ff <= ST_MAC;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bin_index = bin_ff;
   assign rsp_bin_magnitude = mag_ff;
   assign rsp_bin_phase = phase_ff;
   assign rsp_last_bin = last_ff;

endmodule

// ----- design/rdps_check.sv -----
// Port-level checker for the real DFT polar spectrum block, with its bind.
// Depends on rdps_pkg and the top level real_dft_polar_spectrum.
module rdps_check #(
   parameter int POINTS = rdps_pkg::DEF_POINTS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [rdps_pkg::BIN_W-1:0]       rsp_bin_index,
   input logic [rdps_pkg::MAG_W-1:0]       rsp_bin_magnitude,
   input logic [rdps_pkg::PHASE_W-1:0]     rsp_bin_phase,
   input logic                             rsp_last_bin
);
   import rdps_pkg::*;

   localparam logic [BIN_W-1:0] LAST_K = BIN_W'(POINTS / 2);

   // hold a stalled result transaction
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bin_index) && $stable(rsp_bin_magnitude)
         && $stable(rsp_bin_phase))
      else $error("result payload changed while stalled");

   // bin numbers stay in range and the last flag marks the top bin only
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bin_index <= LAST_K)
      else $error("bin index out of range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_bin == (rsp_bin_index == LAST_K)))
      else $error("last flag disagrees with bin index");

   // bins of a frame arrive in order
   a_bin_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_bin ##1 rsp_valid && !$stable(rsp_bin_index)
      |-> rsp_bin_index == $past(rsp_bin_index) + 1'b1)
      else $error("bin order broken");

endmodule

bind real_dft_polar_spectrum rdps_check #(.POINTS(POINTS)) u_rdps_check (.*);
